FILE: design/lrra_pkg.sv
`default_nettype none

package lrra_pkg;

    localparam int unsigned FR_W    = 6;
    localparam int unsigned BR_W    = 23;
    localparam int unsigned FSTEP_W = 5;
    localparam int unsigned BSTEP_W = 21;
    localparam int unsigned LIMIT_W = 16;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 23;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VARY_FRAME_RATE = 4'd0,
        CFG_FRAME_RATE_MIN  = 4'd1,
        CFG_FRAME_RATE_MAX  = 4'd2,
        CFG_BIT_RATE_MIN    = 4'd3,
        CFG_BIT_RATE_MAX    = 4'd4,
        CFG_FRAME_RATE_STEP = 4'd5,
        CFG_BIT_RATE_STEP   = 4'd6,
        CFG_RETRY_LIMIT     = 4'd7
    } t_cfg_idx;

    // Reset values of the registers.
    localparam logic [FR_W-1:0]    RST_FRAME_RATE_MIN  = 6'd24;
    localparam logic [FR_W-1:0]    RST_FRAME_RATE_MAX  = 6'd24;
    localparam logic [BR_W-1:0]    RST_BIT_RATE_MIN    = 23'd4000000;
    localparam logic [BR_W-1:0]    RST_BIT_RATE_MAX    = 23'd4000000;
    localparam logic [FSTEP_W-1:0] RST_FRAME_RATE_STEP = 5'd5;
    localparam logic [BSTEP_W-1:0] RST_BIT_RATE_STEP   = 21'd500000;
    localparam logic [LIMIT_W-1:0] RST_RETRY_LIMIT     = 16'd200;

    // One result as held in the output buffer.
    typedef struct packed {
        logic [FR_W-1:0] frame_rate;
        logic [BR_W-1:0] bit_rate;
        logic            rate_changed;
        logic            congested;
    } t_result;

endpackage

`default_nettype wire

FILE: design/link_retry_rate_adapter_top.sv
// The result of an accepted request is registered in the output buffer, which drives o_valid.
// Throughput: one request per clock while o_stall is low; the rate update is a single compare/add/clamp pass.
// A two-entry output buffer takes one more request while the output is stalled; the input
// then stalls from the next cycle until the skid entry moves up into the main entry.
// Reset (synchronous, i_rst_n low) loads register defaults, sets both rates to their
// maximum, clears the good-tick counter and empties the output buffer.
`default_nettype none

module link_retry_rate_adapter_top #(
    parameter int unsigned GOOD_TICKS    = 15,
    parameter int unsigned TICKS_PER_SEC = 5
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input request channel
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [lrra_pkg::COUNT_W-1:0]        i_retry_count,
    // result channel
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [lrra_pkg::FR_W-1:0]                o_frame_rate_out,
    output logic [lrra_pkg::BR_W-1:0]                o_bit_rate_out,
    output logic                                     o_rate_changed,
    output logic                                     o_congested,
    // configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [lrra_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [lrra_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int unsigned FR_W    = lrra_pkg::FR_W;
    localparam int unsigned BR_W    = lrra_pkg::BR_W;
    localparam int unsigned FSTEP_W = lrra_pkg::FSTEP_W;
    localparam int unsigned BSTEP_W = lrra_pkg::BSTEP_W;
    localparam int unsigned LIMIT_W = lrra_pkg::LIMIT_W;
    localparam int unsigned COUNT_W = lrra_pkg::COUNT_W;
    // Width of the retries-per-second product and of the good-tick counter.
    localparam int unsigned TPS_W   = $clog2(TICKS_PER_SEC + 1);
    localparam int unsigned RATE_W  = COUNT_W + TPS_W;
    localparam int unsigned GOOD_W  = $clog2(GOOD_TICKS + 1);
    localparam logic [TPS_W-1:0]  TPS_K  = TPS_W'(TICKS_PER_SEC);
    localparam logic [GOOD_W-1:0] GOOD_K = GOOD_W'(GOOD_TICKS);

    // Configuration registers.
    logic               r_vary_frame_rate, n_vary_frame_rate;
    logic [FR_W-1:0]    r_frame_rate_min,  n_frame_rate_min;
    logic [FR_W-1:0]    r_frame_rate_max,  n_frame_rate_max;
    logic [BR_W-1:0]    r_bit_rate_min,    n_bit_rate_min;
    logic [BR_W-1:0]    r_bit_rate_max,    n_bit_rate_max;
    logic [FSTEP_W-1:0] r_frame_rate_step, n_frame_rate_step;
    logic [BSTEP_W-1:0] r_bit_rate_step,   n_bit_rate_step;
    logic [LIMIT_W-1:0] r_retry_limit,     n_retry_limit;
    logic               cfg_hit;

    // Adapter state.
    logic [FR_W-1:0]    r_cur_fr, n_cur_fr;
    logic [BR_W-1:0]    r_cur_br, n_cur_br;
    logic [GOOD_W-1:0]  r_good_cnt, n_good_cnt;

    // Output buffer: main entry drives the ports, the skid entry catches one
    // request that arrives while the main entry is stalled.
    logic                r_out_valid, r_skid_valid;
    lrra_pkg::t_result   r_out, r_skid;
    lrra_pkg::t_result   new_res;

    logic in_acc, out_take;

    assign o_stall  = r_skid_valid;
    assign in_acc   = i_valid && !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign out_take = r_out_valid && !i_stall;

    assign o_frame_rate_out = r_out.frame_rate;
    assign o_bit_rate_out   = r_out.bit_rate;
    assign o_rate_changed   = r_out.rate_changed;
    assign o_congested      = r_out.congested;

    // Register write decode. Any write to a known register reloads both
    // current rates from the maximum registers, using the value just written.
    always_comb begin
        n_vary_frame_rate = r_vary_frame_rate;
        n_frame_rate_min  = r_frame_rate_min;
        n_frame_rate_max  = r_frame_rate_max;
        n_bit_rate_min    = r_bit_rate_min;
        n_bit_rate_max    = r_bit_rate_max;
        n_frame_rate_step = r_frame_rate_step;
        n_bit_rate_step   = r_bit_rate_step;
        n_retry_limit     = r_retry_limit;
        cfg_hit           = 1'b0;
        if (i_cfg_we) begin
            cfg_hit = 1'b1;
            unique case (i_cfg_idx)
                lrra_pkg::CFG_VARY_FRAME_RATE: n_vary_frame_rate = i_cfg_data[0];
                lrra_pkg::CFG_FRAME_RATE_MIN:  n_frame_rate_min  = i_cfg_data[FR_W-1:0];
                lrra_pkg::CFG_FRAME_RATE_MAX:  n_frame_rate_max  = i_cfg_data[FR_W-1:0];
                lrra_pkg::CFG_BIT_RATE_MIN:    n_bit_rate_min    = i_cfg_data[BR_W-1:0];
                lrra_pkg::CFG_BIT_RATE_MAX:    n_bit_rate_max    = i_cfg_data[BR_W-1:0];
                lrra_pkg::CFG_FRAME_RATE_STEP: n_frame_rate_step = i_cfg_data[FSTEP_W-1:0];
                lrra_pkg::CFG_BIT_RATE_STEP:   n_bit_rate_step   = i_cfg_data[BSTEP_W-1:0];
                lrra_pkg::CFG_RETRY_LIMIT:     n_retry_limit     = i_cfg_data[LIMIT_W-1:0];
                default:                       cfg_hit           = 1'b0;
            endcase
        end
    end

    // Rate update for one request.
    logic [RATE_W-1:0]  per_sec;
    logic               congested;
    logic               step_up_due;
    logic [GOOD_W-1:0]  good_inc;
    logic [FR_W-1:0]    fr_down, fr_up;
    logic [BR_W-1:0]    br_down, br_up;
    logic [FR_W:0]      fr_sum;
    logic [BR_W:0]      br_sum;
    logic [FR_W-1:0]    upd_fr;
    logic [BR_W-1:0]    upd_br;
    logic [GOOD_W-1:0]  upd_good;

    always_comb begin
        per_sec     = RATE_W'(i_retry_count) * RATE_W'(TPS_K);
        congested   = per_sec > RATE_W'(r_retry_limit);
        good_inc    = r_good_cnt + GOOD_W'(1);
        step_up_due = !congested && (good_inc >= GOOD_K);

        // Step down: hold at or below the minimum, clamp when the step would
        // pass the minimum.
        if (r_cur_fr <= r_frame_rate_min) begin
            fr_down = r_cur_fr;
        end else if (FR_W'(r_frame_rate_step) >= (r_cur_fr - r_frame_rate_min)) begin
            fr_down = r_frame_rate_min;
        end else begin
            fr_down = r_cur_fr - FR_W'(r_frame_rate_step);
        end
        if (r_cur_br <= r_bit_rate_min) begin
            br_down = r_cur_br;
        end else if (BR_W'(r_bit_rate_step) >= (r_cur_br - r_bit_rate_min)) begin
            br_down = r_bit_rate_min;
        end else begin
            br_down = r_cur_br - BR_W'(r_bit_rate_step);
        end

        // Step up by twice the step: hold at or above the maximum, clamp at it.
        fr_sum = {1'b0, r_cur_fr} + {1'b0, (FR_W'(r_frame_rate_step) << 1)};
        br_sum = {1'b0, r_cur_br} + {1'b0, (BR_W'(r_bit_rate_step) << 1)};
        if (r_cur_fr >= r_frame_rate_max) begin
            fr_up = r_cur_fr;
        end else if (fr_sum > {1'b0, r_frame_rate_max}) begin
            fr_up = r_frame_rate_max;
        end else begin
            fr_up = fr_sum[FR_W-1:0];
        end
        if (r_cur_br >= r_bit_rate_max) begin
            br_up = r_cur_br;
        end else if (br_sum > {1'b0, r_bit_rate_max}) begin
            br_up = r_bit_rate_max;
        end else begin
            br_up = br_sum[BR_W-1:0];
        end

        upd_fr   = r_cur_fr;
        upd_br   = r_cur_br;
        upd_good = good_inc;
        if (congested) begin
            upd_good = '0;
            if (r_vary_frame_rate) begin
                upd_fr = fr_down;
            end else begin
                upd_br = br_down;
            end
        end else if (step_up_due) begin
            upd_good = '0;
            if (r_vary_frame_rate) begin
                upd_fr = fr_up;
            end else begin
                upd_br = br_up;
            end
        end

        new_res.frame_rate   = upd_fr;
        new_res.bit_rate     = upd_br;
        new_res.rate_changed = r_vary_frame_rate ? (upd_fr != r_cur_fr)
                                                 : (upd_br != r_cur_br);
        new_res.congested    = congested;
    end

    // Next state. Configuration writes must come only while idle; the block does not
    // enforce it, and a write simply takes priority over the rate update.
    always_comb begin
        n_cur_fr   = r_cur_fr;
        n_cur_br   = r_cur_br;
        n_good_cnt = r_good_cnt;
        if (cfg_hit) begin
            n_cur_fr = n_frame_rate_max;
            n_cur_br = n_bit_rate_max;
        end else if (in_acc) begin
            n_cur_fr   = upd_fr;
            n_cur_br   = upd_br;
            n_good_cnt = upd_good;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vary_frame_rate <= 1'b0;
            r_frame_rate_min  <= lrra_pkg::RST_FRAME_RATE_MIN;
            r_frame_rate_max  <= lrra_pkg::RST_FRAME_RATE_MAX;
            r_bit_rate_min    <= lrra_pkg::RST_BIT_RATE_MIN;
            r_bit_rate_max    <= lrra_pkg::RST_BIT_RATE_MAX;
            r_frame_rate_step <= lrra_pkg::RST_FRAME_RATE_STEP;
            r_bit_rate_step   <= lrra_pkg::RST_BIT_RATE_STEP;
            r_retry_limit     <= lrra_pkg::RST_RETRY_LIMIT;
            r_cur_fr          <= lrra_pkg::RST_FRAME_RATE_MAX;
            r_cur_br          <= lrra_pkg::RST_BIT_RATE_MAX;
            r_good_cnt        <= '0;
        end else begin
            r_vary_frame_rate <= n_vary_frame_rate;
            r_frame_rate_min  <= n_frame_rate_min;
            r_frame_rate_max  <= n_frame_rate_max;
            r_bit_rate_min    <= n_bit_rate_min;
            r_bit_rate_max    <= n_bit_rate_max;
            r_frame_rate_step <= n_frame_rate_step;
            r_bit_rate_step   <= n_bit_rate_step;
            r_retry_limit     <= n_retry_limit;
            r_cur_fr          <= n_cur_fr;
            r_cur_br          <= n_cur_br;
            r_good_cnt        <= n_good_cnt;
        end
    end

    // Output buffer control. A new result goes to the main entry when it is
    // free or being taken, otherwise to the skid entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                if (!r_out_valid || out_take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (!r_out_valid || out_take) begin
                r_out <= new_res;
            end else begin
                r_skid <= new_res;
            end
        end else if (out_take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    // The skid entry only fills behind a held main entry.
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while main entry empty");

    // The good-tick counter always clears on reaching its threshold.
    a_good_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_good_cnt < GOOD_K)
        else $error("good-tick counter reached its threshold");

    // A register write reloads the current frame and bit rates from the maxima.
    a_cfg_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> (r_cur_fr == r_frame_rate_max) && (r_cur_br == r_bit_rate_max))
        else $error("current rates not reloaded after a register write");

    // While the frame rate is varied, the bit rate never moves on a request.
    a_fixed_bit_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !cfg_hit && r_vary_frame_rate) |=> (r_cur_br == $past(r_cur_br)))
        else $error("bit rate moved while frame rate is varied");

    // A congested request never raises the varied rate.
    a_no_rise_when_congested: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && congested) |-> ((upd_fr <= r_cur_fr) && (upd_br <= r_cur_br)))
        else $error("rate rose on a congested tick");

endmodule

`default_nettype wire

FILE: verif/link_retry_rate_adapter_top_tb.sv
`timescale 1ns / 100ps

module link_retry_rate_adapter_top_tb;

    localparam int unsigned GOOD_TICKS    = 15;
    localparam int unsigned TICKS_PER_SEC = 5;

    localparam int unsigned FR_W       = lrra_pkg::FR_W;
    localparam int unsigned BR_W       = lrra_pkg::BR_W;
    localparam int unsigned FSTEP_W    = lrra_pkg::FSTEP_W;
    localparam int unsigned BSTEP_W    = lrra_pkg::BSTEP_W;
    localparam int unsigned LIMIT_W    = lrra_pkg::LIMIT_W;
    localparam int unsigned COUNT_W    = lrra_pkg::COUNT_W;
    localparam int unsigned CFG_IDX_W  = lrra_pkg::CFG_IDX_W;
    localparam int unsigned CFG_DATA_W = lrra_pkg::CFG_DATA_W;

    // Generous ceiling on the whole run.
    localparam int unsigned CYCLE_LIMIT = 200000;
    // Length of the long result-side hold-off that backs the block up.
    localparam int unsigned HOLD_CYCLES = 64;

    // Register indexes past the last register; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 4'd8;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 4'd15;

    // The directed plan mixes requests with register writes.
    typedef enum logic {
        ROW_ITEM,
        ROW_WRITE
    } t_plan_kind;

    typedef struct packed {
        t_plan_kind             kind;
        logic [CFG_IDX_W-1:0]   idx;    // register index of a write
        logic [CFG_DATA_W-1:0]  value;  // retry count of a request, or write data
        logic [7:0]             reps;   // how many times a request row is sent
        logic                   known;  // the result below is typed in by hand
        lrra_pkg::t_result      want;
    } t_plan_row;

    // Results that can be read straight off the reset settings: both bit rate
    // bounds sit at 4000000, so nothing can move yet.
    localparam lrra_pkg::t_result AT_RESET_CALM      = '{6'd24, 23'd4000000, 1'b0, 1'b0};
    localparam lrra_pkg::t_result AT_RESET_CONGESTED = '{6'd24, 23'd4000000, 1'b0, 1'b1};

    localparam int unsigned PLAN_ROWS = 25;
    localparam t_plan_row DIRECTED_PLAN [PLAN_ROWS] = '{
        // Reset settings: zero retries, the exact limit, the largest count and
        // the first count above the limit.
        '{ROW_ITEM,  '0, 23'd0,       8'd1,  1'b1, AT_RESET_CALM},
        '{ROW_ITEM,  '0, 23'd40,      8'd1,  1'b1, AT_RESET_CALM},
        '{ROW_ITEM,  '0, 23'd65535,   8'd1,  1'b1, AT_RESET_CONGESTED},
        '{ROW_ITEM,  '0, 23'd41,      8'd1,  1'b1, AT_RESET_CONGESTED},
        // Bit rate mode with the lowest minimum and the largest step: one plain
        // step down, one that overshoots the minimum, one at the minimum, then a
        // full run of good ticks whose step up overshoots the maximum.
        '{ROW_WRITE, lrra_pkg::CFG_BIT_RATE_MIN,    23'd800000,  8'd0, 1'b0, '0},
        '{ROW_WRITE, lrra_pkg::CFG_BIT_RATE_STEP,   23'd2000000, 8'd0, 1'b0, '0},
        '{ROW_ITEM,  '0, 23'd65535,   8'd1,  1'b0, '0},
        '{ROW_ITEM,  '0, 23'd41,      8'd1,  1'b0, '0},
        '{ROW_ITEM,  '0, 23'd65535,   8'd1,  1'b0, '0},
        '{ROW_ITEM,  '0, 23'd40,      8'd15, 1'b0, '0},
        // Frame rate mode with the minimum above the maximum, the largest step
        // and the largest limit; writes to unused indexes must change nothing.
        '{ROW_WRITE, lrra_pkg::CFG_VARY_FRAME_RATE, 23'd1,       8'd0, 1'b0, '0},
        '{ROW_WRITE, lrra_pkg::CFG_FRAME_RATE_MIN,  23'd60,      8'd0, 1'b0, '0},
        '{ROW_WRITE, lrra_pkg::CFG_FRAME_RATE_MAX,  23'd1,       8'd0, 1'b0, '0},
        '{ROW_WRITE, lrra_pkg::CFG_FRAME_RATE_STEP, 23'd30,      8'd0, 1'b0, '0},
        '{ROW_WRITE, lrra_pkg::CFG_RETRY_LIMIT,     23'd65535,   8'd0, 1'b0, '0},
        '{ROW_WRITE, CFG_SPARE_FIRST,               23'h7FFFFF,  8'd0, 1'b0, '0},
        '{ROW_WRITE, CFG_SPARE_LAST,                23'd0,       8'd0, 1'b0, '0},
        '{ROW_ITEM,  '0, 23'd65535,   8'd1,  1'b0, '0},
        '{ROW_ITEM,  '0, 23'd13107,   8'd1,  1'b0, '0},
        // A zero step never moves the rate, and a zero limit makes a single
        // retry count as congestion.
        '{ROW_WRITE, lrra_pkg::CFG_FRAME_RATE_STEP, 23'd0,       8'd0, 1'b0, '0},
        '{ROW_WRITE, lrra_pkg::CFG_FRAME_RATE_MIN,  23'd1,       8'd0, 1'b0, '0},
        '{ROW_WRITE, lrra_pkg::CFG_FRAME_RATE_MAX,  23'd60,      8'd0, 1'b0, '0},
        '{ROW_WRITE, lrra_pkg::CFG_RETRY_LIMIT,     23'd0,       8'd0, 1'b0, '0},
        '{ROW_ITEM,  '0, 23'd1,       8'd1,  1'b0, '0},
        '{ROW_ITEM,  '0, 23'd0,       8'd1,  1'b0, '0}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic [COUNT_W-1:0]     i_retry_count;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [FR_W-1:0]        o_frame_rate_out;
    logic [BR_W-1:0]        o_bit_rate_out;
    logic                   o_rate_changed;
    logic                   o_congested;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    link_retry_rate_adapter_top #(
        .GOOD_TICKS    (GOOD_TICKS),
        .TICKS_PER_SEC (TICKS_PER_SEC)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_retry_count    (i_retry_count),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_frame_rate_out (o_frame_rate_out),
        .o_bit_rate_out   (o_bit_rate_out),
        .o_rate_changed   (o_rate_changed),
        .o_congested      (o_congested),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    // 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow copy of the register file and the rate state.
    logic                vary_frame;
    logic [FR_W-1:0]     fr_min;
    logic [FR_W-1:0]     fr_max;
    logic [BR_W-1:0]     br_min;
    logic [BR_W-1:0]     br_max;
    logic [FSTEP_W-1:0]  fr_step;
    logic [BSTEP_W-1:0]  br_step;
    logic [LIMIT_W-1:0]  retry_lim;
    logic [FR_W-1:0]     cur_fr;
    logic [BR_W-1:0]     cur_br;
    logic [7:0]          good_ticks;

    // Rate updates that the block still owes, oldest first.
    lrra_pkg::t_result rate_updates_due[$];

    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned cycle_count    = 0;

    // Idle percentages of the two sides; the result side reads its own with
    // the clock, so it is only ever updated with nonblocking assignments.
    int unsigned tx_idle_pct = 19;
    int unsigned rx_idle_pct = 51;

    // Toggling hold_req asks the result side for one long hold-off.
    logic        hold_req  = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_left = 0;

    // Set while requests may still be in flight since the last register write.
    logic traffic_open = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic int unsigned rate_down(input int unsigned cur, input int unsigned lo,
                                              input int unsigned step);
        if (cur <= lo)
            return cur;
        if (step >= cur - lo)
            return lo;
        return cur - step;
    endfunction

    function automatic int unsigned rate_up(input int unsigned cur, input int unsigned hi,
                                            input int unsigned step);
        int unsigned raised;
        if (cur >= hi)
            return cur;
        raised = cur + 2 * step;
        return (raised > hi) ? hi : raised;
    endfunction

    // Any write to a real register reloads both rates from their maximums;
    // the good-tick counter keeps its value.
    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        logic hit;
        hit = 1'b1;
        case (idx)
            lrra_pkg::CFG_VARY_FRAME_RATE: vary_frame = data[0];
            lrra_pkg::CFG_FRAME_RATE_MIN:  fr_min     = data[FR_W-1:0];
            lrra_pkg::CFG_FRAME_RATE_MAX:  fr_max     = data[FR_W-1:0];
            lrra_pkg::CFG_BIT_RATE_MIN:    br_min     = data[BR_W-1:0];
            lrra_pkg::CFG_BIT_RATE_MAX:    br_max     = data[BR_W-1:0];
            lrra_pkg::CFG_FRAME_RATE_STEP: fr_step    = data[FSTEP_W-1:0];
            lrra_pkg::CFG_BIT_RATE_STEP:   br_step    = data[BSTEP_W-1:0];
            lrra_pkg::CFG_RETRY_LIMIT:     retry_lim  = data[LIMIT_W-1:0];
            default:                       hit        = 1'b0;
        endcase
        if (hit) begin
            cur_fr = fr_max;
            cur_br = br_max;
        end
    endfunction

    // One control tick: scale the retry count to a per-second rate, step the
    // varied rate down on congestion, or count a good tick and step it up
    // twice as far once enough good ticks have gone by.
    function automatic lrra_pkg::t_result advance_rates(input logic [COUNT_W-1:0] count);
        int unsigned       per_sec;
        logic [FR_W-1:0]   prior_fr;
        logic [BR_W-1:0]   prior_br;
        lrra_pkg::t_result r;
        per_sec  = int'(count) * TICKS_PER_SEC;
        prior_fr = cur_fr;
        prior_br = cur_br;
        r.congested = (per_sec > retry_lim);
        if (r.congested) begin
            if (vary_frame)
                cur_fr = FR_W'(rate_down(cur_fr, fr_min, fr_step));
            else
                cur_br = BR_W'(rate_down(cur_br, br_min, br_step));
            good_ticks = '0;
        end else begin
            good_ticks = good_ticks + 8'd1;
            if (good_ticks >= GOOD_TICKS) begin
                if (vary_frame)
                    cur_fr = FR_W'(rate_up(cur_fr, fr_max, fr_step));
                else
                    cur_br = BR_W'(rate_up(cur_br, br_max, br_step));
                good_ticks = '0;
            end
        end
        r.frame_rate   = cur_fr;
        r.bit_rate     = cur_br;
        r.rate_changed = vary_frame ? (cur_fr != prior_fr) : (cur_br != prior_br);
        return r;
    endfunction

    // Offers one request, after a random gap, and books its expected result
    // once the block takes it. Valid stays high between back-to-back requests.
    task automatic offer_count(input logic [COUNT_W-1:0] count, input logic use_known,
                               input lrra_pkg::t_result known);
        lrra_pkg::t_result predicted;
        i_cfg_we <= 1'b0;
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_retry_count <= count;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        predicted = advance_rates(count);
        rate_updates_due.push_back(use_known ? known : predicted);
        traffic_open = 1'b1;
    endtask

    // Drops valid and waits until every booked result is back and the block has settled,
    // so that a register write lands on an idle block.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (rate_updates_due.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        traffic_open = 1'b0;
    endtask

    // The write enable is left high; the next request lowers it, so that
    // back-to-back writes never see a low and a high in the same step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_register(idx, data);
    endtask

    // Register value with the bounds favored; now and then a value with every
    // data bit random, which the block truncates to the register width.
    function automatic logic [CFG_DATA_W-1:0] pick_value(input int unsigned lo,
                                                          input int unsigned hi);
        case ($urandom_range(9, 0))
            0:       return CFG_DATA_W'(lo);
            1:       return CFG_DATA_W'(hi);
            2:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(hi, lo));
        endcase
    endfunction

    task automatic program_random_settings();
        write_reg(lrra_pkg::CFG_VARY_FRAME_RATE, CFG_DATA_W'($urandom));
        if ($urandom_range(3, 0) != 0)
            write_reg(lrra_pkg::CFG_FRAME_RATE_MIN, pick_value(1, 60));
        if ($urandom_range(3, 0) != 0)
            write_reg(lrra_pkg::CFG_FRAME_RATE_MAX, pick_value(1, 60));
        if ($urandom_range(3, 0) != 0)
            write_reg(lrra_pkg::CFG_BIT_RATE_MIN, pick_value(800000, 6000000));
        if ($urandom_range(3, 0) != 0)
            write_reg(lrra_pkg::CFG_BIT_RATE_MAX, pick_value(800000, 6000000));
        if ($urandom_range(3, 0) != 0)
            write_reg(lrra_pkg::CFG_FRAME_RATE_STEP, pick_value(0, 30));
        if ($urandom_range(3, 0) != 0)
            write_reg(lrra_pkg::CFG_BIT_RATE_STEP, pick_value(100000, 2000000));
        if ($urandom_range(3, 0) != 0)
            write_reg(lrra_pkg::CFG_RETRY_LIMIT, pick_value(0, 65535));
        write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST)),
                  CFG_DATA_W'($urandom));
    endtask

    // Mostly runs of calm ticks, at times long enough to reach a step up, followed by
    // short bursts of congestion; the rest are single counts from the whole
    // field range.
    task automatic run_traffic(input int unsigned n);
        int unsigned sent;
        int unsigned calm_max;
        int unsigned run_len;
        sent = 0;
        while (sent < n) begin
            calm_max = retry_lim / TICKS_PER_SEC;
            if ($urandom_range(99, 0) < 80) begin
                run_len = $urandom_range(20, 1);
                repeat (run_len)
                    offer_count(COUNT_W'($urandom_range(calm_max, 0)), 1'b0, '0);
                sent += run_len;
                run_len = $urandom_range(3, 0);
                repeat (run_len)
                    offer_count(COUNT_W'($urandom_range(16'hFFFF, calm_max + 1)), 1'b0, '0);
                sent += run_len;
            end else begin
                offer_count(COUNT_W'($urandom), 1'b0, '0);
                sent++;
            end
        end
    endtask

    // Result side: checks each accepted result against the oldest booked one
    // and decides the stall for the next edge, including the long hold-off.
    always @(posedge i_clk) begin : result_side
        lrra_pkg::t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (rate_updates_due.size() == 0) begin
                report_mismatch("result arrived with no request outstanding");
            end else begin
                want = rate_updates_due.pop_front();
                if (o_frame_rate_out !== want.frame_rate)
                    report_mismatch($sformatf("result %0d frame_rate_out %0d, expected %0d",
                                              results_seen, o_frame_rate_out, want.frame_rate));
                if (o_bit_rate_out !== want.bit_rate)
                    report_mismatch($sformatf("result %0d bit_rate_out %0d, expected %0d",
                                              results_seen, o_bit_rate_out, want.bit_rate));
                if (o_rate_changed !== want.rate_changed)
                    report_mismatch($sformatf("result %0d rate_changed %b, expected %b",
                                              results_seen, o_rate_changed, want.rate_changed));
                if (o_congested !== want.congested)
                    report_mismatch($sformatf("result %0d congested %b, expected %b",
                                              results_seen, o_congested, want.congested));
                results_seen++;
            end
        end
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99, 0) < rx_idle_pct);
        end
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("link_retry_rate_adapter_top_tb NOT OK");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_retry_count <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;

        // Shadow state as it stands after reset.
        vary_frame = 1'b0;
        fr_min     = lrra_pkg::RST_FRAME_RATE_MIN;
        fr_max     = lrra_pkg::RST_FRAME_RATE_MAX;
        br_min     = lrra_pkg::RST_BIT_RATE_MIN;
        br_max     = lrra_pkg::RST_BIT_RATE_MAX;
        fr_step    = lrra_pkg::RST_FRAME_RATE_STEP;
        br_step    = lrra_pkg::RST_BIT_RATE_STEP;
        retry_lim  = lrra_pkg::RST_RETRY_LIMIT;
        cur_fr     = lrra_pkg::RST_FRAME_RATE_MAX;
        cur_br     = lrra_pkg::RST_BIT_RATE_MAX;
        good_ticks = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, walked row by row; writes wait for an idle block.
        for (int row = 0; row < PLAN_ROWS; row++) begin
            if (DIRECTED_PLAN[row].kind == ROW_WRITE) begin
                if (traffic_open)
                    wait_idle();
                write_reg(DIRECTED_PLAN[row].idx, DIRECTED_PLAN[row].value);
            end else begin
                repeat (DIRECTED_PLAN[row].reps)
                    offer_count(DIRECTED_PLAN[row].value[COUNT_W-1:0],
                                DIRECTED_PLAN[row].known, DIRECTED_PLAN[row].want);
            end
        end

        // Random part: three idling patterns, six register settings each.
        for (int pattern = 0; pattern < 3; pattern++) begin
            case (pattern)
                0: begin
                    tx_idle_pct = 19;
                    rx_idle_pct <= 51;
                end
                1: begin
                    tx_idle_pct = 51;
                    rx_idle_pct <= 19;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                end
            endcase
            for (int round = 0; round < 6; round++) begin
                if (traffic_open)
                    wait_idle();
                program_random_settings();
                // With neither side idling, a long hold-off on the result side
                // fills the output buffer and pushes back on the requests.
                if (pattern == 2 && round == 0)
                    hold_req <= ~hold_req;
                run_traffic(90);
            end
        end

        wait_idle();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("link_retry_rate_adapter_top_tb OK");
        else
            $display("link_retry_rate_adapter_top_tb NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
design/lrra_pkg.sv
design/link_retry_rate_adapter_top.sv
verif/link_retry_rate_adapter_top_tb.sv
